// File: sv/obb_pkg.sv
// obb_pkg: shared types, constants and status codes of the orthonormal basis builder.
// No dependencies; imported by obb_norm, the top level and the checker.
package obb_pkg;

  localparam int COMP_W    = 32;              // one vector component
  localparam int SUM_W     = 64;              // squared length
  localparam int FRAC      = 30;              // output fraction bits
  localparam int CFG_W     = 32;              // widest register
  localparam int MARGIN_W  = 31;

  // obb_norm pipeline: square, sum, two normalize steps, sqrt, divide prep,
  // divide, sign/clamp
  localparam int SQRT_ST   = 16;              // two root bits per stage
  localparam int DIV_ST    = 16;              // two quotient bits per stage
  localparam int NORM_LAT  = 4 + SQRT_ST + 1 + DIV_ST + 1;
  localparam int TOTAL_LAT = 2 * NORM_LAT + 6;

  localparam int IN_DATA_W  = 6 * COMP_W;
  localparam int OUT_DATA_W = 296;            // 9 * 32 + 2, padded to bytes

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_PAR   = 2'd2;

  localparam logic       REG_MIN_LEN = 1'b0;
  localparam logic       REG_MARGIN  = 1'b1;

  typedef logic [2:0][COMP_W-1:0] vec_t;

endpackage

// File: sv/obb_norm.sv
// obb_norm: pipelined unit-vector scaler (square, sum, normalize, sqrt, divide).
// Depends on obb_pkg. Every stage advances only when en is high.
module obb_norm (
  input  logic          clk,
  input  logic          en,
  input  obb_pkg::vec_t mag,   // component magnitudes
  input  logic [2:0]    neg,   // component signs
  output obb_pkg::vec_t unit,  // signed unit components, FRAC fraction bits
  output logic [63:0]   ssq    // exact squared length
);
  import obb_pkg::*;

  localparam logic [31:0] ONE = 32'd1 << FRAC;

  // stage A: squares
  vec_t             a_mag;
  logic [2:0]       a_neg;
  logic [2:0][63:0] a_sq;
  // stage B: sum
  vec_t             b_mag;
  logic [2:0]       b_neg;
  logic [63:0]      b_s;
  // stage C: coarse normalize
  vec_t             c_mag;
  logic [2:0]       c_neg;
  logic [63:0]      c_s;
  logic [63:0]      c_ssq;
  logic [4:0]       c_k;
  logic [63:0]      c_s_next;
  logic [4:0]       c_k_next;
  logic [63:0]      d_s_next;
  logic [4:0]       d_k_next;

  // sqrt chain, index 0 is the fine normalize stage
  logic [63:0] q_n   [SQRT_ST+1];
  logic [63:0] q_res [SQRT_ST+1];
  vec_t        q_mag [SQRT_ST+1];
  logic [2:0]  q_neg [SQRT_ST+1];
  logic [4:0]  q_k   [SQRT_ST+1];
  logic [63:0] q_ssq [SQRT_ST+1];

  // divide chain, index 0 is the dividend prep stage
  vec_t        v_r   [DIV_ST+1];
  vec_t        v_lo  [DIV_ST+1];
  vec_t        v_q   [DIV_ST+1];
  logic [31:0] v_len [DIV_ST+1];
  logic [2:0]  v_neg [DIV_ST+1];
  logic [63:0] v_ssq [DIV_ST+1];

  function automatic logic [127:0] sqrt_step(input logic [63:0] n, input logic [63:0] res,
                                             input int j);
    logic [63:0] bitv;
    logic [64:0] trial;
    logic [63:0] n_o;
    logic [63:0] r_o;
    bitv  = 64'd1 << (62 - 2 * j);
    trial = {1'b0, res} + {1'b0, bitv};
    if ({1'b0, n} >= trial) begin
      n_o = n - trial[63:0];
      r_o = (res >> 1) + bitv;
    end else begin
      n_o = n;
      r_o = res >> 1;
    end
    return {n_o, r_o};
  endfunction

  function automatic logic [32:0] div_step(input logic [31:0] r, input logic dbit,
                                           input logic [31:0] len);
    logic [32:0] t;
    logic        qb;
    t  = {r, dbit};
    qb = (t >= {1'b0, len});
    if (qb) t = t - {1'b0, len};
    return {qb, t[31:0]};
  endfunction

  always_comb begin
    c_s_next = b_s;
    c_k_next = '0;
    if (c_s_next[63:32] == '0) begin
      c_s_next = c_s_next << 32;
      c_k_next = c_k_next + 5'd16;
    end
    if (c_s_next[63:48] == '0) begin
      c_s_next = c_s_next << 16;
      c_k_next = c_k_next + 5'd8;
    end
    if (c_s_next[63:56] == '0) begin
      c_s_next = c_s_next << 8;
      c_k_next = c_k_next + 5'd4;
    end
    d_s_next = c_s;
    d_k_next = c_k;
    if (d_s_next[63:60] == '0) begin
      d_s_next = d_s_next << 4;
      d_k_next = d_k_next + 5'd2;
    end
    if (d_s_next[63:62] == '0) begin
      d_s_next = d_s_next << 2;
      d_k_next = d_k_next + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag <= mag;
      a_neg <= neg;
      for (int i = 0; i < 3; i++) a_sq[i] <= mag[i] * mag[i];
      b_mag <= a_mag;
      b_neg <= a_neg;
      b_s   <= a_sq[0] + a_sq[1] + a_sq[2];
      c_mag <= b_mag;
      c_neg <= b_neg;
      c_ssq <= b_s;
      c_s   <= c_s_next;
      c_k   <= c_k_next;
      q_n[0]   <= d_s_next;
      q_res[0] <= '0;
      q_mag[0] <= c_mag;
      q_neg[0] <= c_neg;
      q_k[0]   <= d_k_next;
      q_ssq[0] <= c_ssq;
    end
  end

  for (genvar g = 0; g < SQRT_ST; g++) begin : g_sqrt
    logic [127:0] s1;
    logic [127:0] s2;
    always_comb begin
      s1 = sqrt_step(q_n[g], q_res[g], 2 * g);
      s2 = sqrt_step(s1[127:64], s1[63:0], 2 * g + 1);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q_n[g+1]   <= s2[127:64];
        q_res[g+1] <= s2[63:0];
        q_mag[g+1] <= q_mag[g];
        q_neg[g+1] <= q_neg[g];
        q_k[g+1]   <= q_k[g];
        q_ssq[g+1] <= q_ssq[g];
      end
    end
  end

  // dividend = (mag << k << FRAC) + len/2; its top part is below len
  logic [31:0]      p_len;
  logic [2:0][93:0] p_num;
  always_comb begin
    p_len = q_res[SQRT_ST][31:0];
    for (int i = 0; i < 3; i++) begin
      p_num[i] = ((94'(q_mag[SQRT_ST][i]) << q_k[SQRT_ST]) << FRAC) + 94'(p_len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v_r[0][i]  <= p_num[i][63:32];
        v_lo[0][i] <= p_num[i][31:0];
        v_q[0][i]  <= '0;
      end
      v_len[0] <= p_len;
      v_neg[0] <= q_neg[SQRT_ST];
      v_ssq[0] <= q_ssq[SQRT_ST];
    end
  end

  for (genvar g = 0; g < DIV_ST; g++) begin : g_div
    vec_t r_n, lo_n, q_n2;
    logic [32:0] t1, t2;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t1 = div_step(v_r[g][i], v_lo[g][i][31], v_len[g]);
        t2 = div_step(t1[31:0], v_lo[g][i][30], v_len[g]);
        r_n[i]  = t2[31:0];
        lo_n[i] = v_lo[g][i] << 2;
        q_n2[i] = {v_q[g][i][29:0], t1[32], t2[32]};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        v_r[g+1]   <= r_n;
        v_lo[g+1]  <= lo_n;
        v_q[g+1]   <= q_n2;
        v_len[g+1] <= v_len[g];
        v_neg[g+1] <= v_neg[g];
        v_ssq[g+1] <= v_ssq[g];
      end
    end
  end

  vec_t unit_next;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_next[i] = (v_q[DIV_ST][i] > ONE) ? ONE : v_q[DIV_ST][i];
      if (v_neg[DIV_ST][i]) unit_next[i] = -unit_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit <= unit_next;
      ssq  <= v_ssq[DIV_ST];
    end
  end

endmodule

// File: sv/orthonormal_basis_builder.sv
// orthonormal_basis_builder: Gram-Schmidt right-handed basis from two 3-vectors.
// Depends on obb_pkg and obb_norm (two instances for u and v, one for the remainder).
//
//  channel  dir  word fields (lowest bit first)
//  s_*      in   u_x u_y u_z v_x v_y v_z, 32 bits each, Q16.16
//  m_*      out  axis1_x..axis3_z 32 bits each Q2.30, status 2 bits, 6 zero pad bits
//  cfg_*    in   index 0 min_length_sq, index 1 parallel_margin (bits 30:0)
//
// One word accepted per cycle while the output is not stalled; the pipeline holds two
// scaling chains of NORM_LAT = 38 stages (bit-pair square root and divider).
// rst is synchronous and clears only valid bits and the two registers.
// The whole pipeline advances whenever the output register is empty or taken;
// on a stall every stage holds, so nothing is lost or repeated.
module orthonormal_basis_builder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [obb_pkg::IN_DATA_W-1:0]  s_tdata,   // u_x u_y u_z v_x v_y v_z
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [obb_pkg::OUT_DATA_W-1:0] m_tdata,   // axis1_xyz axis2_xyz axis3_xyz status
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [obb_pkg::CFG_W-1:0]      cfg_data
);
  import obb_pkg::*;

  localparam logic signed [36:0] ONE_37 = 37'sd1 <<< FRAC;

  logic [CFG_W-1:0]    min_length_sq;
  logic [MARGIN_W-1:0] parallel_margin;

  logic                 en;
  logic [TOTAL_LAT-1:0] vld;

  assign en       = !vld[TOTAL_LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length_sq   <= CFG_W'(1);
      parallel_margin <= MARGIN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_LEN: min_length_sq   <= cfg_data;
        REG_MARGIN:  parallel_margin <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL_LAT-2:0], s_tvalid};
    end
  end

  // round half away from zero, 2*FRAC to FRAC fraction bits
  function automatic logic signed [36:0] round_prod(input logic signed [65:0] p);
    logic [65:0] m;
    logic [35:0] r;
    m = p[65] ? -p : p;
    r = 36'((m + (66'd1 << (FRAC - 1))) >> FRAC);
    return p[65] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  // input magnitudes and signs
  vec_t       u_mag, v_mag;
  logic [2:0] u_neg, v_neg;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_neg[i] = s_tdata[COMP_W*i + COMP_W-1];
      v_neg[i] = s_tdata[COMP_W*(i+3) + COMP_W-1];
      u_mag[i] = u_neg[i] ? -s_tdata[COMP_W*i +: COMP_W] : s_tdata[COMP_W*i +: COMP_W];
      v_mag[i] = v_neg[i] ? -s_tdata[COMP_W*(i+3) +: COMP_W]
                          : s_tdata[COMP_W*(i+3) +: COMP_W];
    end
  end

  vec_t        a1, vn, a2;
  logic [63:0] su, sv, sr;

  obb_norm u_norm_u (.clk, .en, .mag(u_mag), .neg(u_neg), .unit(a1), .ssq(su));
  obb_norm u_norm_v (.clk, .en, .mag(v_mag), .neg(v_neg), .unit(vn), .ssq(sv));

  // E1: length checks, dot product terms
  logic                    e1_short;
  logic signed [2:0][63:0] e1_p;
  vec_t                    e1_a1, e1_vn;
  // E2: cosine
  logic signed [32:0]      e2_cos;
  logic                    e2_short;
  vec_t                    e2_a1, e2_vn;
  // E3: parallel test, projection terms
  logic                    e3_par, e3_short;
  logic signed [2:0][65:0] e3_prod;
  vec_t                    e3_a1, e3_vn;
  // E4: remainder vector
  vec_t                    e4_mag, e4_a1;
  logic [2:0]              e4_neg;
  logic [1:0]              e4_st;

  logic signed [65:0] dot;
  logic signed [36:0] cos_r;
  logic [32:0]        cos_abs;
  logic signed [33:0] thr;
  logic signed [36:0] rem [3];

  // packed elements read back unsigned, so each term is sign-extended explicitly
  always_comb begin
    dot     = 66'($signed(e1_p[0])) + 66'($signed(e1_p[1])) + 66'($signed(e1_p[2]));
    cos_r   = round_prod(dot);
    cos_abs = e2_cos[32] ? -e2_cos : e2_cos;
    thr     = (34'sd1 <<< FRAC) - $signed({3'b000, parallel_margin});
    for (int i = 0; i < 3; i++) begin
      rem[i] = 37'($signed(e3_vn[i])) - round_prod(e3_prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_short <= (su == '0) || (su < 64'(min_length_sq)) ||
                  (sv == '0) || (sv < 64'(min_length_sq));
      for (int i = 0; i < 3; i++) e1_p[i] <= $signed(a1[i]) * $signed(vn[i]);
      e1_a1 <= a1;
      e1_vn <= vn;

      e2_cos   <= cos_r[32:0];
      e2_short <= e1_short;
      e2_a1    <= e1_a1;
      e2_vn    <= e1_vn;

      e3_par   <= $signed({1'b0, cos_abs}) > thr;
      e3_short <= e2_short;
      for (int i = 0; i < 3; i++) begin
        e3_prod[i] <= 66'(e2_cos) * 66'($signed(e2_a1[i]));
      end
      e3_a1 <= e2_a1;
      e3_vn <= e2_vn;

      for (int i = 0; i < 3; i++) begin
        e4_neg[i] <= rem[i][36];
        e4_mag[i] <= rem[i][36] ? 32'(-rem[i]) : rem[i][31:0];
      end
      e4_a1 <= e3_a1;
      e4_st <= e3_short ? ST_SHORT : (e3_par ? ST_PAR : ST_OK);
    end
  end

  obb_norm u_norm_r (.clk, .en, .mag(e4_mag), .neg(e4_neg), .unit(a2), .ssq(sr));

  // first axis and status ride alongside the remainder scaling
  vec_t       sb_a1 [NORM_LAT];
  logic [1:0] sb_st [NORM_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      sb_a1[0] <= e4_a1;
      sb_st[0] <= e4_st;
      for (int i = 1; i < NORM_LAT; i++) begin
        sb_a1[i] <= sb_a1[i-1];
        sb_st[i] <= sb_st[i-1];
      end
    end
  end

  // F1: final status, cross product terms
  logic [1:0]              f1_st;
  vec_t                    f1_a1, f1_a2;
  logic signed [5:0][63:0] f1_p;
  vec_t                    a1_l, a2_l;

  always_comb begin
    a1_l = sb_a1[NORM_LAT-1];
    a2_l = a2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sb_st[NORM_LAT-1] != ST_OK) f1_st <= sb_st[NORM_LAT-1];
      else if (sr == '0)              f1_st <= ST_PAR;
      else                            f1_st <= ST_OK;
      f1_p[0] <= $signed(a1_l[1]) * $signed(a2_l[2]);
      f1_p[1] <= $signed(a1_l[2]) * $signed(a2_l[1]);
      f1_p[2] <= $signed(a1_l[2]) * $signed(a2_l[0]);
      f1_p[3] <= $signed(a1_l[0]) * $signed(a2_l[2]);
      f1_p[4] <= $signed(a1_l[0]) * $signed(a2_l[1]);
      f1_p[5] <= $signed(a1_l[1]) * $signed(a2_l[0]);
      f1_a1 <= a1_l;
      f1_a2 <= a2_l;
    end
  end

  // output register
  logic signed [36:0]       cr [3];
  logic [OUT_DATA_W-1:0]    out_next;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = round_prod(66'($signed(f1_p[2*i])) - 66'($signed(f1_p[2*i+1])));
      if (cr[i] > ONE_37)       cr[i] = ONE_37;
      else if (cr[i] < -ONE_37) cr[i] = -ONE_37;
    end
    out_next = '0;
    if (f1_st == ST_OK) begin
      for (int i = 0; i < 3; i++) begin
        out_next[COMP_W*i +: COMP_W]     = f1_a1[i];
        out_next[COMP_W*(i+3) +: COMP_W] = f1_a2[i];
        out_next[COMP_W*(i+6) +: COMP_W] = cr[i][31:0];
      end
    end
    out_next[9*COMP_W +: 2] = f1_st;
  end

  always_ff @(posedge clk) begin
    if (en) m_tdata <= out_next;
  end

endmodule

// File: sv/obb_checker.sv
// obb_checker: port-level assertions for orthonormal_basis_builder, bound to the top.
// Depends on obb_pkg.
module obb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [obb_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [obb_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           cfg_we,
  input logic                           cfg_index,
  input logic [obb_pkg::CFG_W-1:0]      cfg_data
);
  import obb_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[9*COMP_W +: 2] == ST_OK || m_tdata[9*COMP_W +: 2] == ST_SHORT ||
                 m_tdata[9*COMP_W +: 2] == ST_PAR)
    else $error("unknown status code");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9*COMP_W +: 2] != ST_OK |-> m_tdata[9*COMP_W-1:0] == '0)
    else $error("axes not cleared on error");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind orthonormal_basis_builder obb_checker u_obb_checker (.*);
